FILE: src/banked_interrupt_controller_assert.svh
// Assertion macros shared by the interrupt controller RTL.
`ifndef BANKED_INTERRUPT_CONTROLLER_ASSERT_SVH
`define BANKED_INTERRUPT_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked on every clock once out of reset.
`define BIC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock once out of reset.
`define BIC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/bic_pkg.sv
// Package: widths, request and register codes, priority encoder for the controller.
package bic_pkg;

    localparam int BASIC_W   = 8;
    localparam int BANK_W    = 32;
    localparam int NUM_W     = 7;
    localparam int LINE_W    = 5;
    localparam int REQ_W     = 2;
    localparam int SUMMARY_W = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    // Request codes; code 3 is unused and behaves as a sample
    typedef enum logic [REQ_W-1:0] {
        REQ_SAMPLE  = 2'd0,
        REQ_ENABLE  = 2'd1,
        REQ_DISABLE = 2'd2
    } t_req;

    // Bank codes, upper two bits of an interrupt number
    localparam logic [1:0] BANK_BASIC = 2'd0;
    localparam logic [1:0] BANK_ONE   = 2'd1;
    localparam logic [1:0] BANK_TWO   = 2'd2;
    localparam logic [1:0] BANK_NONE  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_BASIC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_BANK1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_BANK2 = 2'd2;

    // Index of the lowest set bit; 31 for an all-zero word
    function automatic logic [LINE_W-1:0] lowest_bit(input logic [BANK_W-1:0] w);
        logic [LINE_W-1:0] n;
        n = LINE_W'(BANK_W - 1);
        for (int i = BANK_W - 1; i >= 0; i--) begin
            if (w[i]) begin
                n = LINE_W'(i);
            end
        end
        return n;
    endfunction

endpackage

FILE: src/banked_interrupt_controller.sv
// Top level: three-bank interrupt controller with lowest-number-first selection.
//
//  Channel  Direction  Handshake                Payload
//  in       to block   i_in_valid / o_in_ready  req_type, irq_number, raw lines
//  out      from block o_out_valid/ i_out_ready found, selected, summary, bad flag
//  cfg      to block   i_cfg_we (no wait)       index, data (valid masks)
//
// One transaction per cycle sustained while the output is not stalled; a result passes
// the pending-word register, then the result register, of the two-stage pipeline.
// Enable masks update at acceptance, before the pending words are formed.
// Synchronous active-low reset clears enables, valid masks and valid flags.
// A stalled output holds the result register; input stalls only once both
// stages are full.
module banked_interrupt_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [bic_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bic_pkg::CFG_W-1:0]         i_cfg_data,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [bic_pkg::REQ_W-1:0]         i_req_type,
    input  logic [bic_pkg::NUM_W-1:0]         i_irq_number,
    input  logic [bic_pkg::BASIC_W-1:0]       i_raw_basic,
    input  logic [bic_pkg::BANK_W-1:0]        i_raw_bank1,
    input  logic [bic_pkg::BANK_W-1:0]        i_raw_bank2,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_irq_found,
    output logic [bic_pkg::NUM_W-1:0]         o_irq_selected,
    output logic [bic_pkg::SUMMARY_W-1:0]     o_basic_summary,
    output logic                              o_bad_request
);
    import bic_pkg::*;

    `include "banked_interrupt_controller_assert.svh"

    // configuration registers
    logic [BASIC_W-1:0] r_valid_basic;
    logic [BANK_W-1:0]  r_valid_bank1;
    logic [BANK_W-1:0]  r_valid_bank2;

    // enable state
    logic [BASIC_W-1:0] r_en_basic, n_en_basic;
    logic [BANK_W-1:0]  r_en_bank1, n_en_bank1;
    logic [BANK_W-1:0]  r_en_bank2, n_en_bank2;

    // stage one: pending words
    logic               r_s1_valid;
    logic [BASIC_W-1:0] r_p0;
    logic [BANK_W-1:0]  r_p1;
    logic [BANK_W-1:0]  r_p2;
    logic               r_s1_bad;

    // stage two: result register
    logic                 r_out_valid;
    logic                 r_found;
    logic [NUM_W-1:0]     r_sel;
    logic [SUMMARY_W-1:0] r_summary;
    logic                 r_bad;

    logic in_accept, s1_move, out_free;

    // handshake
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;
    assign in_accept  = i_in_valid && o_in_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_basic <= '0;
            r_valid_bank1 <= '0;
            r_valid_bank2 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_VALID_BASIC: r_valid_basic <= i_cfg_data[BASIC_W-1:0];
                CFG_VALID_BANK1: r_valid_bank1 <= i_cfg_data;
                CFG_VALID_BANK2: r_valid_bank2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // enable update decode
    logic [1:0]        req_bank;
    logic [LINE_W-1:0] req_line;
    logic [BANK_W-1:0] line_bit;
    logic              is_upd, is_en, req_bad;

    always_comb begin
        req_bank = i_irq_number[NUM_W-1:LINE_W];
        req_line = i_irq_number[LINE_W-1:0];
        line_bit = BANK_W'(1) << req_line;
        is_en    = (i_req_type == REQ_ENABLE);
        is_upd   = is_en || (i_req_type == REQ_DISABLE);
        req_bad  = is_upd && (((req_bank == BANK_BASIC) && (req_line >= LINE_W'(BASIC_W)))
                              || (req_bank == BANK_NONE));

        n_en_basic = r_en_basic;
        n_en_bank1 = r_en_bank1;
        n_en_bank2 = r_en_bank2;
        if (is_upd && !req_bad) begin
            case (req_bank)
                BANK_BASIC: n_en_basic = is_en ? (r_en_basic | line_bit[BASIC_W-1:0])
                                               : (r_en_basic & ~line_bit[BASIC_W-1:0]);
                BANK_ONE:   n_en_bank1 = is_en ? (r_en_bank1 | line_bit)
                                               : (r_en_bank1 & ~line_bit);
                BANK_TWO:   n_en_bank2 = is_en ? (r_en_bank2 | line_bit)
                                               : (r_en_bank2 & ~line_bit);
                default: ;
            endcase
        end
    end

    // enable state and stage one valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en_basic <= '0;
            r_en_bank1 <= '0;
            r_en_bank2 <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_en_basic <= n_en_basic;
                r_en_bank1 <= n_en_bank1;
                r_en_bank2 <= n_en_bank2;
            end
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // pending words use the updated enables
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_p0     <= i_raw_basic & n_en_basic;
            r_p1     <= i_raw_bank1 & n_en_bank1;
            r_p2     <= i_raw_bank2 & n_en_bank2;
            r_s1_bad <= req_bad;
        end
    end

    // summary and bank selection
    logic                 more1, more2, found;
    logic [1:0]           sel_bank;
    logic [BANK_W-1:0]    sel_bits;
    logic [NUM_W-1:0]     sel_num;
    logic [SUMMARY_W-1:0] summary;

    always_comb begin
        more1    = |r_p1;
        more2    = |r_p2;
        summary  = {more2, more1, r_p0};
        sel_bank = BANK_BASIC;
        sel_bits = '0;
        if (|r_p0) begin
            sel_bits = BANK_W'(r_p0 & r_valid_basic);
        end
        if ((sel_bits == '0) && more1) begin
            sel_bank = BANK_ONE;
            sel_bits = r_p1 & r_valid_bank1;
        end
        if ((sel_bits == '0) && more2) begin
            sel_bank = BANK_TWO;
            sel_bits = r_p2 & r_valid_bank2;
        end
        found   = |sel_bits;
        sel_num = found ? {sel_bank, lowest_bit(sel_bits)} : '0;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_found   <= found;
            r_sel     <= sel_num;
            r_summary <= summary;
            r_bad     <= r_s1_bad;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_irq_found     = r_found;
    assign o_irq_selected  = r_sel;
    assign o_basic_summary = r_summary;
    assign o_bad_request   = r_bad;

    // checks
    `BIC_ASSERT_IMP(a_none_is_zero, o_out_valid && !o_irq_found, o_irq_selected == '0,
        "no interrupt found but selection is nonzero")
    `BIC_ASSERT_IMP(a_bank_in_range, o_out_valid && o_irq_found,
        o_irq_selected[NUM_W-1:LINE_W] != BANK_NONE, "selected bank out of range")
    `BIC_ASSERT_IMP(a_basic_pending,
        o_out_valid && o_irq_found && (o_irq_selected[NUM_W-1:LINE_W] == BANK_BASIC),
        (o_irq_selected[4:3] == 2'd0) && o_basic_summary[o_irq_selected[2:0]],
        "basic selection not backed by a pending basic line")
    `BIC_ASSERT_IMP(a_bank1_summary,
        o_out_valid && o_irq_found && (o_irq_selected[NUM_W-1:LINE_W] == BANK_ONE),
        o_basic_summary[BASIC_W], "bank one selected without its summary bit")
    `BIC_ASSERT_NXT(a_stage_advance, r_s1_valid && out_free && !in_accept,
        !r_s1_valid && r_out_valid, "stage one did not drain into the result register")
endmodule

FILE: verif/tb.sv
// Testbench for the three-bank interrupt controller: directed and random traffic.
`timescale 1ns / 1ps

module tb;
    import bic_pkg::*;

    localparam int CLK_HALF     = 1;
    localparam int RESET_CYCLES = 7;
    localparam int PIPE_LATENCY = 4;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_MAX   = 10;
    localparam int PHASE_ITEMS  = 200;
    localparam logic [BANK_W-1:0] ALL_ONES = 32'hffff_ffff;

    // request code 3 has no enum member; it acts as a plain sample
    localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;

    typedef enum logic [1:0] {
        STALL_NEVER,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall;

    typedef struct packed {
        logic                 found;
        logic [NUM_W-1:0]     sel;
        logic [SUMMARY_W-1:0] summary;
        logic                 bad;
    } t_irq_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_W-1:0]       i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic [REQ_W-1:0]       i_req_type = '0;
    logic [NUM_W-1:0]       i_irq_number = '0;
    logic [BASIC_W-1:0]     i_raw_basic = '0;
    logic [BANK_W-1:0]      i_raw_bank1 = '0;
    logic [BANK_W-1:0]      i_raw_bank2 = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic                   o_irq_found;
    logic [NUM_W-1:0]       o_irq_selected;
    logic [SUMMARY_W-1:0]   o_basic_summary;
    logic                   o_bad_request;

    // shadow copy of the controller state
    logic [BASIC_W-1:0] en_basic = '0;
    logic [BANK_W-1:0]  en_bank1 = '0;
    logic [BANK_W-1:0]  en_bank2 = '0;
    logic [BASIC_W-1:0] vm_basic = '0;
    logic [BANK_W-1:0]  vm_bank1 = '0;
    logic [BANK_W-1:0]  vm_bank2 = '0;

    t_irq_result pending_results[$];
    int          n_failures = 0;
    int          cycle_count = 0;
    t_stall      stall_mode = STALL_NEVER;
    int          stall_left = 0;

    banked_interrupt_controller uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_irq_number   (i_irq_number),
        .i_raw_basic    (i_raw_basic),
        .i_raw_bank1    (i_raw_bank1),
        .i_raw_bank2    (i_raw_bank2),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_irq_found    (o_irq_found),
        .o_irq_selected (o_irq_selected),
        .o_basic_summary(o_basic_summary),
        .o_bad_request  (o_bad_request)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // receiver back-pressure: four random modes, each held for a random time
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= t_stall'($urandom_range(0, 3));
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NEVER:  i_out_ready <= 1'b1;
            STALL_LIGHT:  i_out_ready <= ($urandom_range(0, 3) != 0);
            STALL_HEAVY:  i_out_ready <= ($urandom_range(0, 3) == 0);
            default:      i_out_ready <= (cycle_count % 7) < 3;
        endcase
    end

    // result checker: every output transaction against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_irq_result got;
        t_irq_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_irq_found, o_irq_selected, o_basic_summary, o_bad_request};
            if (pending_results.size() == 0) begin
                n_failures++;
                if (n_failures <= REPORT_MAX)
                    $display("tb: unexpected result found=%0d sel=%0d summary=%h bad=%0d",
                             got.found, got.sel, got.summary, got.bad);
            end else begin
                want = pending_results.pop_front();
                if (got.found !== want.found || got.sel !== want.sel ||
                    got.summary !== want.summary || got.bad !== want.bad) begin
                    n_failures++;
                    if (n_failures <= REPORT_MAX)
                        $display("tb: mismatch at cycle %0d: expected found=%0d sel=%0d ",
                                 cycle_count, want.found, want.sel,
                                 "summary=%h bad=%0d, ", want.summary, want.bad,
                                 "got found=%0d sel=%0d summary=%h bad=%0d",
                                 got.found, got.sel, got.summary, got.bad);
                end
            end
        end
    end

    // index of the lowest set bit of a non-zero word
    function automatic logic [LINE_W-1:0] first_set_line(logic [BANK_W-1:0] w);
        logic [BANK_W-1:0] isolated;
        logic [LINE_W-1:0] idx;
        isolated = w & (~w + 1'b1);
        idx = '0;
        for (int i = 0; i < BANK_W; i++)
            if (isolated[i])
                idx = LINE_W'(i);
        return idx;
    endfunction

    // apply the request to the shadow enables, then form the expected result
    function automatic t_irq_result resolve_interrupt(logic [REQ_W-1:0] req,
                                                      logic [NUM_W-1:0] num,
                                                      logic [BASIC_W-1:0] raw0,
                                                      logic [BANK_W-1:0] raw1,
                                                      logic [BANK_W-1:0] raw2);
        t_irq_result       r;
        logic [1:0]        bank;
        logic [LINE_W-1:0] line;
        logic              set_it;
        logic [BASIC_W-1:0] p0;
        logic [BANK_W-1:0] p1;
        logic [BANK_W-1:0] p2;
        logic [BANK_W-1:0] cand;
        logic [1:0]        win_bank;
        bank   = num[NUM_W-1:LINE_W];
        line   = num[LINE_W-1:0];
        set_it = (req == REQ_ENABLE);
        r.bad  = 1'b0;
        if (req == REQ_ENABLE || req == REQ_DISABLE) begin
            case (bank)
                BANK_BASIC: begin
                    if (line >= LINE_W'(BASIC_W))
                        r.bad = 1'b1;
                    else
                        en_basic[line[2:0]] = set_it;
                end
                BANK_ONE: en_bank1[line] = set_it;
                BANK_TWO: en_bank2[line] = set_it;
                default:  r.bad = 1'b1;
            endcase
        end
        p0 = raw0 & en_basic;
        p1 = raw1 & en_bank1;
        p2 = raw2 & en_bank2;
        r.summary = {|p2, |p1, p0};

        // first bank in priority order with a pending valid line wins
        win_bank = BANK_BASIC;
        cand     = '0;
        if (p0 != '0)
            cand = {{(BANK_W-BASIC_W){1'b0}}, p0 & vm_basic};
        if (cand == '0 && p1 != '0) begin
            win_bank = BANK_ONE;
            cand     = p1 & vm_bank1;
        end
        if (cand == '0 && p2 != '0) begin
            win_bank = BANK_TWO;
            cand     = p2 & vm_bank2;
        end
        r.found = (cand != '0);
        r.sel   = r.found ? {win_bank, first_set_line(cand)} : '0;
        return r;
    endfunction

    // one input transaction; valid stays high on return for back-to-back items
    task automatic send_request(logic [REQ_W-1:0] req, logic [NUM_W-1:0] num,
                                logic [BASIC_W-1:0] raw0, logic [BANK_W-1:0] raw1,
                                logic [BANK_W-1:0] raw2);
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_irq_number <= num;
        i_raw_basic  <= raw0;
        i_raw_bank1  <= raw1;
        i_raw_bank2  <= raw2;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        pending_results.push_back(resolve_interrupt(req, num, raw0, raw1, raw2));
    endtask

    task automatic hold_off(int cycles);
        if (cycles > 0) begin
            i_in_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // stop sending and wait until the pipeline is empty
    task automatic drain;
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LATENCY) @(posedge i_clk);
    endtask

    // write all three valid masks; the block must be idle
    task automatic program_valid_masks(logic [BASIC_W-1:0] m0, logic [BANK_W-1:0] m1,
                                       logic [BANK_W-1:0] m2);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_VALID_BASIC;
        i_cfg_data  <= CFG_W'(m0);
        @(posedge i_clk);
        i_cfg_index <= CFG_VALID_BANK1;
        i_cfg_data  <= m1;
        @(posedge i_clk);
        i_cfg_index <= CFG_VALID_BANK2;
        i_cfg_data  <= m2;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        vm_basic = m0;
        vm_bank1 = m1;
        vm_bank2 = m2;
    endtask

    // raw line patterns: empty, full, random, single line, sparse
    function automatic logic [BANK_W-1:0] raw_pattern;
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return ALL_ONES;
            4:       return BANK_W'(1) << $urandom_range(0, BANK_W - 1);
            5:       return $urandom & $urandom & $urandom;
            default: return $urandom;
        endcase
    endfunction

    // mostly enable/disable of real lines, some samples, some malformed requests
    task automatic send_random_request;
        int unsigned      pick;
        logic [REQ_W-1:0] req;
        logic [NUM_W-1:0] num;
        logic [BASIC_W-1:0] raw0;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            req = REQ_ENABLE;
        else if (pick < 65)
            req = REQ_DISABLE;
        else if (pick < 85)
            req = REQ_SAMPLE;
        else
            req = REQ_W'($urandom_range(0, 3));
        if (pick < 65)
            num = ($urandom_range(0, 3) == 0) ? NUM_W'($urandom_range(0, 7))
                                              : NUM_W'($urandom_range(32, 95));
        else if (pick >= 85 && $urandom_range(0, 1) == 0)
            num = ($urandom_range(0, 1) == 0) ? NUM_W'($urandom_range(8, 31))
                                              : NUM_W'($urandom_range(96, 127));
        else
            num = NUM_W'($urandom_range(0, 127));
        raw0 = BASIC_W'(raw_pattern());
        send_request(req, num, raw0, raw_pattern(), raw_pattern());
    endtask

    // out of reset: nothing enabled and no valid lines
    task automatic test_reset_defaults;
        send_request(REQ_SAMPLE, 7'd0, 8'hff, ALL_ONES, ALL_ONES);
        send_request(REQ_ENABLE, 7'd0, 8'hff, ALL_ONES, ALL_ONES);
        send_request(REQ_DISABLE, 7'd0, 8'hff, ALL_ONES, ALL_ONES);
        drain();
    endtask

    // enable/disable across every bank, bad numbers and the unused code
    task automatic test_enable_requests;
        program_valid_masks(8'hff, ALL_ONES, ALL_ONES);
        send_request(REQ_ENABLE, 7'd7, 8'h80, 32'h0, 32'h0);
        send_request(REQ_ENABLE, 7'd0, 8'hff, 32'h0, 32'h0);
        send_request(REQ_ENABLE, 7'd8, 8'hff, ALL_ONES, ALL_ONES);
        send_request(REQ_DISABLE, 7'd31, 8'hff, ALL_ONES, ALL_ONES);
        send_request(REQ_ENABLE, 7'd63, 8'h00, ALL_ONES, 32'h0);
        send_request(REQ_ENABLE, 7'd32, 8'h00, 32'h8000_0001, 32'h0);
        send_request(REQ_ENABLE, 7'd95, 8'h00, 32'h0, ALL_ONES);
        send_request(REQ_ENABLE, 7'd64, 8'h00, 32'h0, 32'h8000_0000);
        send_request(REQ_ENABLE, 7'd96, 8'hff, ALL_ONES, ALL_ONES);
        send_request(REQ_DISABLE, 7'd127, 8'hff, ALL_ONES, ALL_ONES);
        send_request(REQ_RESERVED, 7'd8, 8'hff, ALL_ONES, ALL_ONES);
        send_request(REQ_RESERVED, 7'd127, 8'h00, 32'h0, 32'h0);
        send_request(REQ_SAMPLE, 7'd100, 8'h01, 32'h0, 32'h0);
        send_request(REQ_DISABLE, 7'd0, 8'hff, ALL_ONES, ALL_ONES);
        send_request(REQ_DISABLE, 7'd7, 8'hff, ALL_ONES, ALL_ONES);
        drain();
    endtask

    // invalid lines in a higher-priority bank push selection to the next bank
    task automatic test_priority_fallback;
        send_request(REQ_ENABLE, 7'd3, 8'hff, ALL_ONES, ALL_ONES);
        drain();
        program_valid_masks(8'h00, ALL_ONES, ALL_ONES);
        send_request(REQ_SAMPLE, 7'd0, 8'hff, ALL_ONES, ALL_ONES);
        drain();
        program_valid_masks(8'h00, 32'h0, ALL_ONES);
        send_request(REQ_SAMPLE, 7'd0, 8'hff, ALL_ONES, ALL_ONES);
        send_request(REQ_DISABLE, 7'd64, 8'hff, ALL_ONES, ALL_ONES);
        drain();
        program_valid_masks(8'h00, 32'h0, 32'h0);
        send_request(REQ_SAMPLE, 7'd0, 8'hff, ALL_ONES, ALL_ONES);
        drain();
    endtask

    // random traffic in phases, each under its own valid mask setting
    task automatic test_random_phases;
        int sent;
        int burst;
        for (int phase = 0; phase < 8; phase++) begin
            drain();
            case (phase)
                0: program_valid_masks(8'hff, ALL_ONES, ALL_ONES);
                1: program_valid_masks(8'h00, 32'h0, 32'h0);
                3: program_valid_masks(8'h00, ALL_ONES, ALL_ONES);
                4: program_valid_masks(BASIC_W'($urandom & $urandom), $urandom & $urandom,
                                       $urandom & $urandom);
                6: program_valid_masks(8'hff, ALL_ONES, ALL_ONES);
                7: program_valid_masks(8'(1 << $urandom_range(0, 7)),
                                       BANK_W'(1) << $urandom_range(0, 31),
                                       BANK_W'(1) << $urandom_range(0, 31));
                default: program_valid_masks(BASIC_W'($urandom), $urandom, $urandom);
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100)
                                                    : $urandom_range(1, 24);
                for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
                    send_random_request();
                    sent++;
                end
                hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_enable_requests();
        test_priority_fallback();
        test_random_phases();
        drain();
        if (n_failures == 0 && pending_results.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
